// ----- sv/stc_pkg.sv -----
// Shared codes, defaults and controller/datapath interface types for the symbol table.
package stc_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_ADDR_WIDTH  = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_EXISTS    = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_busy;
    } t_stat;

endpackage

// ----- sv/stc_ctrl.sv -----
// Sequencing state machine for accept, table scan, drain and commit of one item.
module stc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  stc_pkg::t_stat i_stat,
    output stc_pkg::t_cmd  o_cmd
);
    import stc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/stc_dpath.sv -----
// Key and address memories, valid bits, scan compare, symbol count and result register.
module stc_dpath #(
    parameter int TABLE_DEPTH = stc_pkg::DEF_TABLE_DEPTH,
    parameter int ADDR_WIDTH  = stc_pkg::DEF_ADDR_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stc_pkg::t_cmd  i_cmd,
    output stc_pkg::t_stat o_stat,
    input  logic [1:0]     i_op,
    input  logic [63:0]    i_label_low,
    input  logic [7:0]     i_label_high,
    input  logic [15:0]    i_address_value,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [1:0]     o_status,
    output logic           o_found,
    output logic [6:0]     o_entry_count
);
    import stc_pkg::*;

    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W = 72;

    logic [KEY_W-1:0]      r_key_mem  [TABLE_DEPTH];
    logic [ADDR_WIDTH-1:0] r_addr_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;

    logic [1:0]            r_op;
    logic [63:0]           r_key_lo;
    logic [7:0]            r_key_hi;
    logic [ADDR_WIDTH-1:0] r_addr;
    logic [63:0]           n_key_lo;
    logic [7:0]            n_key_hi;
    logic                  seen_zero;

    logic [IW-1:0]         r_idx;
    logic [KEY_W-1:0]      r_rd_key;
    logic                  r_rd_vld;
    logic [IW-1:0]         r_rd_idx;
    logic                  r_cmp_en;
    logic                  match;

    logic                  r_hit;
    logic [IW-1:0]         r_hit_idx;
    logic                  r_free;
    logic [IW-1:0]         r_free_idx;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [1:0]            n_status;
    logic                  wr_en;
    logic                  clr_en;

    logic                  r_out_valid;
    logic [1:0]            r_status;
    logic                  r_found;
    logic [6:0]            r_entry_count;

    // Bytes after the first zero byte are forced to zero, as string compare sees them.
    always_comb begin
        n_key_lo  = '0;
        seen_zero = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (i_label_low[8*b +: 8] == 8'd0) begin
                seen_zero = 1'b1;
            end
            if (!seen_zero) begin
                n_key_lo[8*b +: 8] = i_label_low[8*b +: 8];
            end
        end
        n_key_hi = seen_zero ? 8'd0 : i_label_high;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_key_lo <= n_key_lo;
            r_key_hi <= n_key_hi;
            r_addr   <= ADDR_WIDTH'(i_address_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_key_mem[r_free_idx]  <= {r_key_hi, r_key_lo};
            r_addr_mem[r_free_idx] <= r_addr;
        end
        if (i_cmd.scan) begin
            r_rd_key <= r_key_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_vld <= r_valid[r_idx];
            r_rd_idx <= r_idx;
        end
    end

    assign match = r_rd_vld && (r_rd_key == {r_key_hi, r_key_lo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_cmp_en <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.scan;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.scan) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.load) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else if (r_cmp_en) begin
                if (match) begin
                    r_hit <= 1'b1;
                end
                if (!r_rd_vld) begin
                    r_free <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_en && match && !r_hit) begin
            r_hit_idx <= r_rd_idx;
        end
        if (r_cmp_en && !r_rd_vld && !r_free) begin
            r_free_idx <= r_rd_idx;
        end
    end

    always_comb begin
        n_status = ST_DONE;
        wr_en    = 1'b0;
        clr_en   = 1'b0;
        n_count  = r_count;
        case (r_op)
            OP_INSERT: begin
                if (r_hit) begin
                    n_status = ST_EXISTS;
                end else if (!r_free) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = i_cmd.commit;
                    n_count = r_count + CW'(1);
                end
            end
            OP_DELETE: begin
                if (!r_hit) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    clr_en = i_cmd.commit;
                    if (r_count != '0) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            OP_SEARCH: begin
                if (!r_hit) begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (clr_en) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status      <= n_status;
            r_found       <= r_hit;
            r_entry_count <= 7'(n_count);
        end
    end

    assign o_stat.last     = (r_idx == IW'(TABLE_DEPTH - 1));
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_found         = r_found;
    assign o_entry_count   = r_entry_count;

`ifndef ASSERT_OFF
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("symbol count differs from number of valid entries");

    a_commit_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !(r_out_valid && !i_out_ready))
        else $error("commit while result register still holds an item");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("result not presented after commit");

    a_no_scan_during_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load && (i_cmd.scan || i_cmd.commit)))
        else $error("load overlaps scan or commit");
`endif

endmodule

// ----- sv/symbol_table_cam_core.sv -----
// Top level of the symbol table: insert, delete and search of nine-character labels.
// Each item is accepted in idle, scanned against every table entry, drained, then committed to the result register.
// A new item is accepted only after the last one is committed; commit waits while the result is not yet taken.
// Reset: synchronous; valid bits, symbol count and control state clear.
module symbol_table_cam_core #(
    parameter int TABLE_DEPTH = stc_pkg::DEF_TABLE_DEPTH,
    parameter int ADDR_WIDTH  = stc_pkg::DEF_ADDR_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_label_low,
    input  logic [7:0]  i_label_high,
    input  logic [15:0] i_address_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [6:0]  o_entry_count
);
    import stc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    stc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    stc_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (i_op),
        .i_label_low     (i_label_low),
        .i_label_high    (i_label_high),
        .i_address_value (i_address_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_entry_count   (o_entry_count)
    );

endmodule
